/* hw/rtl/cps_pkg.sv */
package cps_pkg;

  localparam int MaxChunk   = 48;
  localparam int MaxPayload = 65536;
  localparam int FifoDepth  = 4;
  localparam int PtrW       = $clog2(FifoDepth);
  localparam int CountW     = $clog2(FifoDepth + 1);

  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_START,
    PH_DATA,
    PH_WAIT_CHUNK,
    PH_WAIT_END
  } phase_t;

  localparam logic [2:0] CMD_BEGIN       = 3'd0;
  localparam logic [2:0] CMD_START_REPLY = 3'd1;
  localparam logic [2:0] CMD_DATA        = 3'd2;
  localparam logic [2:0] CMD_CHUNK_REPLY = 3'd3;
  localparam logic [2:0] CMD_END_REPLY   = 3'd4;

  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_CHUNK   = 3'd1;
  localparam logic [2:0] ACT_END     = 3'd2;
  localparam logic [2:0] ACT_ABORT   = 3'd3;
  localparam logic [2:0] ACT_SKIPPED = 3'd4;
  localparam logic [2:0] ACT_DONE    = 3'd5;
  localparam logic [2:0] ACT_FAILED  = 3'd6;
  localparam logic [2:0] ACT_IGNORED = 3'd7;

  localparam logic CFG_PAYLOAD_TYPE = 1'b0;
  localparam logic CFG_CHUNK_SIZE   = 1'b1;

  // One queued transaction; pre_abort puts an abort ahead of it on the output.
  typedef struct packed {
    logic [2:0]  action;
    logic [16:0] length;
    logic [31:0] crc;
    logic [31:0] rid;
    logic [15:0] offset;
    logic        pre_abort;
  } result_t;

  function automatic logic [31:0] nib_tab(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'h0:    v = 32'h0000_0000;
      4'h1:    v = 32'h1DB7_1064;
      4'h2:    v = 32'h3B6E_20C8;
      4'h3:    v = 32'h26D9_30AC;
      4'h4:    v = 32'h76DC_4190;
      4'h5:    v = 32'h6B6B_51F4;
      4'h6:    v = 32'h4DB2_6158;
      4'h7:    v = 32'h5005_713C;
      4'h8:    v = 32'hEDB8_8320;
      4'h9:    v = 32'hF00F_9344;
      4'hA:    v = 32'hD6D6_A3E8;
      4'hB:    v = 32'hCB61_B38C;
      4'hC:    v = 32'h9B64_C2B0;
      4'hD:    v = 32'h86D3_D2D4;
      4'hE:    v = 32'hA00A_E278;
      default: v = 32'hBDBD_F21C;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] t;
    t = c ^ {24'h0, b};
    t = nib_tab(t[3:0]) ^ {4'h0, t[31:4]};
    t = nib_tab(t[3:0]) ^ {4'h0, t[31:4]};
    return t;
  endfunction

endpackage

/* hw/rtl/chunked_payload_sender_core.sv */
// A result transaction is registered in the result queue when its input is accepted.
// Throughput: one input per cycle while the 4-entry result queue has room; an
//   input that yields abort then failed offers the abort first, then the failed result.
// Reset (rst, synchronous): phase idle, transfer state cleared, CRC all ones,
//   chunk_size 48, result queue empty.
module chunked_payload_sender_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [16:0] total_length,
  input  logic [31:0] total_crc,
  input  logic        info_answered,
  input  logic [7:0]  info_status,
  input  logic [31:0] info_size,
  input  logic [31:0] info_crc,
  input  logic [7:0]  completion_code,
  input  logic        reply_short,
  input  logic [31:0] reply_resource_id,
  input  logic [7:0]  data_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [16:0] length_out,
  output logic [31:0] crc_out,
  output logic [31:0] resource_id_out,
  output logic [15:0] offset_out,
  output logic        last
);

  // payload_type only travels with requests in the transport; it has no
  // effect on any result here, so writes to it are accepted and dropped.
  logic [5:0] chunk_size;

  cps_pkg::phase_t phase, phase_next;
  logic [16:0] length_total, length_total_next;
  logic [31:0] reservation, reservation_next;
  logic [16:0] sent_offset, sent_offset_next;
  logic [5:0]  bytes_in_chunk, bytes_in_chunk_next;
  logic [31:0] running_crc, running_crc_next;

  cps_pkg::result_t fifo [cps_pkg::FifoDepth];
  logic [cps_pkg::PtrW-1:0]   wr_ptr, rd_ptr;
  logic [cps_pkg::CountW-1:0] count;
  logic                       abort_sent;

  logic             accept;
  logic             push;
  logic             pop;
  cps_pkg::result_t res;
  cps_pkg::result_t head;
  logic             abort_view;
  logic [5:0]       chunk_eff;
  logic [31:0]      crc_new;
  logic [5:0]       bic_new;
  logic [17:0]      fill_end;
  logic [16:0]      offset_sum;

  assign in_stall = (count == cps_pkg::CountW'(cps_pkg::FifoDepth));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= 6'd48;
    end else if (cfg_write && cfg_index == cps_pkg::CFG_CHUNK_SIZE) begin
      chunk_size <= cfg_data[5:0];
    end
  end

  always_comb begin
    if (chunk_size == 6'd0) begin
      chunk_eff = 6'd1;
    end else if (chunk_size > 6'(cps_pkg::MaxChunk)) begin
      chunk_eff = 6'(cps_pkg::MaxChunk);
    end else begin
      chunk_eff = chunk_size;
    end
  end

  assign crc_new    = cps_pkg::crc_byte(running_crc, data_value);
  assign bic_new    = bytes_in_chunk + 6'd1;
  assign fill_end   = {1'b0, sent_offset} + {12'h0, bic_new};
  assign offset_sum = sent_offset + {11'h0, bytes_in_chunk};

  always_comb begin
    phase_next          = phase;
    length_total_next   = length_total;
    reservation_next    = reservation;
    sent_offset_next    = sent_offset;
    bytes_in_chunk_next = bytes_in_chunk;
    running_crc_next    = running_crc;
    push                = 1'b0;
    res                 = '0;
    if (accept) begin
      if (command == cps_pkg::CMD_BEGIN) begin
        phase_next          = cps_pkg::PH_IDLE;
        length_total_next   = '0;
        reservation_next    = '0;
        sent_offset_next    = '0;
        bytes_in_chunk_next = '0;
        running_crc_next    = cps_pkg::CrcOnes;
        push                = 1'b1;
        if (total_length == 17'd0 || total_length > 17'(cps_pkg::MaxPayload)) begin
          res.action = cps_pkg::ACT_FAILED;
        end else if (info_answered && info_status == 8'h01 &&
                     info_size == {15'h0, total_length} && info_crc == total_crc) begin
          res.action = cps_pkg::ACT_SKIPPED;
        end else begin
          length_total_next = total_length;
          phase_next        = cps_pkg::PH_WAIT_START;
          res.action        = cps_pkg::ACT_START;
          res.length        = total_length;
          res.crc           = total_crc;
        end
      end else if (command == cps_pkg::CMD_START_REPLY && phase == cps_pkg::PH_WAIT_START) begin
        if (reply_short || completion_code != 8'd0) begin
          phase_next          = cps_pkg::PH_IDLE;
          length_total_next   = '0;
          reservation_next    = '0;
          sent_offset_next    = '0;
          bytes_in_chunk_next = '0;
          running_crc_next    = cps_pkg::CrcOnes;
          push                = 1'b1;
          res.action          = cps_pkg::ACT_FAILED;
        end else begin
          reservation_next = reply_resource_id;
          phase_next       = cps_pkg::PH_DATA;
        end
      end else if (command == cps_pkg::CMD_DATA && phase == cps_pkg::PH_DATA) begin
        bytes_in_chunk_next = bic_new;
        if (bic_new >= chunk_eff || fill_end >= {1'b0, length_total}) begin
          running_crc_next = cps_pkg::CrcOnes;
          phase_next       = cps_pkg::PH_WAIT_CHUNK;
          push             = 1'b1;
          res.action       = cps_pkg::ACT_CHUNK;
          res.length       = {11'h0, bic_new};
          res.crc          = crc_new ^ cps_pkg::CrcOnes;
          res.rid          = reservation;
          res.offset       = sent_offset[15:0];
        end else begin
          running_crc_next = crc_new;
        end
      end else if (command == cps_pkg::CMD_CHUNK_REPLY && phase == cps_pkg::PH_WAIT_CHUNK) begin
        if (completion_code != 8'd0) begin
          phase_next          = cps_pkg::PH_IDLE;
          length_total_next   = '0;
          reservation_next    = '0;
          sent_offset_next    = '0;
          bytes_in_chunk_next = '0;
          running_crc_next    = cps_pkg::CrcOnes;
          push                = 1'b1;
          res.action          = cps_pkg::ACT_FAILED;
          res.pre_abort       = 1'b1;
        end else begin
          sent_offset_next    = offset_sum;
          bytes_in_chunk_next = '0;
          if (offset_sum >= length_total) begin
            phase_next = cps_pkg::PH_WAIT_END;
            push       = 1'b1;
            res.action = cps_pkg::ACT_END;
            res.rid    = reservation;
          end else begin
            phase_next = cps_pkg::PH_DATA;
          end
        end
      end else if (command == cps_pkg::CMD_END_REPLY && phase == cps_pkg::PH_WAIT_END) begin
        phase_next          = cps_pkg::PH_IDLE;
        length_total_next   = '0;
        reservation_next    = '0;
        sent_offset_next    = '0;
        bytes_in_chunk_next = '0;
        running_crc_next    = cps_pkg::CrcOnes;
        push                = 1'b1;
        if (completion_code != 8'd0) begin
          res.action    = cps_pkg::ACT_FAILED;
          res.pre_abort = 1'b1;
        end else begin
          res.action = cps_pkg::ACT_DONE;
        end
      end else begin
        push       = 1'b1;
        res.action = cps_pkg::ACT_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= cps_pkg::PH_IDLE;
      length_total   <= '0;
      reservation    <= '0;
      sent_offset    <= '0;
      bytes_in_chunk <= '0;
      running_crc    <= cps_pkg::CrcOnes;
    end else begin
      phase          <= phase_next;
      length_total   <= length_total_next;
      reservation    <= reservation_next;
      sent_offset    <= sent_offset_next;
      bytes_in_chunk <= bytes_in_chunk_next;
      running_crc    <= running_crc_next;
    end
  end

  // Result queue
  assign head       = fifo[rd_ptr];
  assign out_valid  = (count != '0);
  assign abort_view = head.pre_abort && !abort_sent;
  assign pop        = out_valid && !out_stall && !abort_view;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      abort_sent <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
      if (pop) begin
        abort_sent <= 1'b0;
      end else if (out_valid && !out_stall && abort_view) begin
        abort_sent <= 1'b1;
      end
    end
  end

  always_comb begin
    if (abort_view) begin
      action          = cps_pkg::ACT_ABORT;
      length_out      = '0;
      crc_out         = '0;
      resource_id_out = '0;
      offset_out      = '0;
      last            = 1'b0;
    end else begin
      action          = head.action;
      length_out      = head.length;
      crc_out         = head.crc;
      resource_id_out = head.rid;
      offset_out      = head.offset;
      last            = 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_abort_sent_head: assert property (@(posedge clk) disable iff (rst)
    abort_sent |-> (out_valid && head.pre_abort))
    else $error("abort marked sent without a pending abort entry");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == cps_pkg::PH_IDLE) |-> (length_total == '0 && sent_offset == '0 &&
                                      bytes_in_chunk == '0))
    else $error("idle phase with transfer state left over");

  a_chunk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == cps_pkg::PH_WAIT_CHUNK) |-> (bytes_in_chunk != '0))
    else $error("waiting on chunk reply with empty chunk");

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == cps_pkg::PH_DATA) |-> (sent_offset < length_total))
    else $error("taking data past the payload length");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a pushed transaction");
`endif

endmodule

/* verif/tb_chunked_payload_sender_core.sv */
`timescale 1ns / 1ps

module tb_chunked_payload_sender_core;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [7:0] PEER_VALID   = 8'h01;
  localparam int         MaxGap       = 11;

  typedef struct packed {
    logic [2:0]  command;
    logic [16:0] total_length;
    logic [31:0] total_crc;
    logic        info_answered;
    logic [7:0]  info_status;
    logic [31:0] info_size;
    logic [31:0] info_crc;
    logic [7:0]  completion_code;
    logic        reply_short;
    logic [31:0] reply_resource_id;
    logic [7:0]  data_value;
  } upload_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [16:0] length;
    logic [31:0] crc;
    logic [31:0] rid;
    logic [15:0] offset;
    logic        last;
  } upload_result_t;

  class upload_scoreboard;
    logic [7:0]      payload_type;
    logic [5:0]      chunk_size;
    cps_pkg::phase_t phase;
    logic [16:0]     length_total;
    logic [31:0]     reservation;
    logic [16:0]     sent_offset;
    logic [5:0]      bytes_in_chunk;
    logic [31:0]     running_crc;
    upload_result_t  expected_results[$];
    int              mismatches;

    function new();
      payload_type = 8'h01;
      chunk_size   = 6'd48;
      mismatches   = 0;
      clear_transfer();
    endfunction

    function void clear_transfer();
      phase          = cps_pkg::PH_IDLE;
      length_total   = '0;
      reservation    = '0;
      sent_offset    = '0;
      bytes_in_chunk = '0;
      running_crc    = cps_pkg::CrcOnes;
    endfunction

    function void set_reg(logic idx, logic [7:0] data);
      if (idx == cps_pkg::CFG_PAYLOAD_TYPE) begin
        payload_type = data;
      end else begin
        chunk_size = data[5:0];
      end
    endfunction

    function int eff_chunk();
      if (chunk_size == 0) return 1;
      if (chunk_size > cps_pkg::MaxChunk) return cps_pkg::MaxChunk;
      return int'(chunk_size);
    endfunction

    // reflected CRC32, one bit at a time
    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      c = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
      end
      return c;
    endfunction

    function void push_result(logic [2:0] act, logic [16:0] len, logic [31:0] crc,
                              logic [31:0] rid, logic [15:0] off, logic fin);
      upload_result_t r;
      r.action = act;
      r.length = len;
      r.crc    = crc;
      r.rid    = rid;
      r.offset = off;
      r.last   = fin;
      expected_results.push_back(r);
    endfunction

    function void note_item(upload_item_t it);
      if (it.command == cps_pkg::CMD_BEGIN) begin
        clear_transfer();
        if (it.total_length == 0 || it.total_length > cps_pkg::MaxPayload) begin
          push_result(cps_pkg::ACT_FAILED, '0, '0, '0, '0, 1'b1);
        end else if (it.info_answered && it.info_status == PEER_VALID &&
                     it.info_size == {15'h0, it.total_length} &&
                     it.info_crc == it.total_crc) begin
          push_result(cps_pkg::ACT_SKIPPED, '0, '0, '0, '0, 1'b1);
        end else begin
          length_total = it.total_length;
          phase        = cps_pkg::PH_WAIT_START;
          push_result(cps_pkg::ACT_START, it.total_length, it.total_crc, '0, '0, 1'b1);
        end
      end else if (it.command == cps_pkg::CMD_START_REPLY &&
                   phase == cps_pkg::PH_WAIT_START) begin
        if (it.reply_short || it.completion_code != 0) begin
          clear_transfer();
          push_result(cps_pkg::ACT_FAILED, '0, '0, '0, '0, 1'b1);
        end else begin
          reservation = it.reply_resource_id;
          phase       = cps_pkg::PH_DATA;
        end
      end else if (it.command == cps_pkg::CMD_DATA && phase == cps_pkg::PH_DATA) begin
        running_crc    = crc_step(running_crc, it.data_value);
        bytes_in_chunk = bytes_in_chunk + 6'd1;
        if (int'(bytes_in_chunk) >= eff_chunk() ||
            int'(sent_offset) + int'(bytes_in_chunk) >= int'(length_total)) begin
          push_result(cps_pkg::ACT_CHUNK, {11'h0, bytes_in_chunk},
                      running_crc ^ cps_pkg::CrcOnes, reservation, sent_offset[15:0], 1'b1);
          running_crc = cps_pkg::CrcOnes;
          phase       = cps_pkg::PH_WAIT_CHUNK;
        end
      end else if (it.command == cps_pkg::CMD_CHUNK_REPLY &&
                   phase == cps_pkg::PH_WAIT_CHUNK) begin
        if (it.completion_code != 0) begin
          clear_transfer();
          push_result(cps_pkg::ACT_ABORT, '0, '0, '0, '0, 1'b0);
          push_result(cps_pkg::ACT_FAILED, '0, '0, '0, '0, 1'b1);
        end else begin
          sent_offset    = sent_offset + {11'h0, bytes_in_chunk};
          bytes_in_chunk = '0;
          if (sent_offset >= length_total) begin
            phase = cps_pkg::PH_WAIT_END;
            push_result(cps_pkg::ACT_END, '0, '0, reservation, '0, 1'b1);
          end else begin
            phase = cps_pkg::PH_DATA;
          end
        end
      end else if (it.command == cps_pkg::CMD_END_REPLY &&
                   phase == cps_pkg::PH_WAIT_END) begin
        clear_transfer();
        if (it.completion_code != 0) begin
          push_result(cps_pkg::ACT_ABORT, '0, '0, '0, '0, 1'b0);
          push_result(cps_pkg::ACT_FAILED, '0, '0, '0, '0, 1'b1);
        end else begin
          push_result(cps_pkg::ACT_DONE, '0, '0, '0, '0, 1'b1);
        end
      end else begin
        push_result(cps_pkg::ACT_IGNORED, '0, '0, '0, '0, 1'b1);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(upload_result_t got);
      upload_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: action %0d", got.action);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare("action", 32'(want.action), 32'(got.action));
      compare("length_out", 32'(want.length), 32'(got.length));
      compare("crc_out", want.crc, got.crc);
      compare("resource_id_out", want.rid, got.rid);
      compare("offset_out", 32'(want.offset), 32'(got.offset));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_write;
  logic         cfg_index;
  logic [7:0]   cfg_data;
  logic         in_valid;
  logic         in_stall;
  upload_item_t drv;
  logic         out_valid;
  logic         out_stall;
  logic [2:0]   action;
  logic [16:0]  length_out;
  logic [31:0]  crc_out;
  logic [31:0]  resource_id_out;
  logic [15:0]  offset_out;
  logic         last;

  upload_scoreboard sb;
  int  items_sent;
  bit  in_calm;
  bit  out_calm;

  chunked_payload_sender_core dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .command           (drv.command),
    .total_length      (drv.total_length),
    .total_crc         (drv.total_crc),
    .info_answered     (drv.info_answered),
    .info_status       (drv.info_status),
    .info_size         (drv.info_size),
    .info_crc          (drv.info_crc),
    .completion_code   (drv.completion_code),
    .reply_short       (drv.reply_short),
    .reply_resource_id (drv.reply_resource_id),
    .data_value        (drv.data_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .action            (action),
    .length_out        (length_out),
    .crc_out           (crc_out),
    .resource_id_out   (resource_id_out),
    .offset_out        (offset_out),
    .last              (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // toggle runs of back-to-back traffic on either side
  initial begin
    in_calm  = 1'b0;
    out_calm = 1'b0;
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic upload_item_t any_fields(logic [2:0] cmd);
    upload_item_t it;
    it.command           = cmd;
    it.total_length      = 17'($urandom_range(0, 17'h1FFFF));
    it.total_crc         = $urandom();
    it.info_answered     = 1'($urandom_range(0, 1));
    it.info_status       = 8'($urandom_range(0, 255));
    it.info_size         = $urandom();
    it.info_crc          = $urandom();
    it.completion_code   = 8'($urandom_range(0, 255));
    it.reply_short       = 1'($urandom_range(0, 1));
    it.reply_resource_id = $urandom();
    it.data_value        = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // peer_has: the peer holds a matching copy; otherwise at least one condition fails
  function automatic upload_item_t begin_item(int len, bit peer_has);
    upload_item_t it;
    it = any_fields(cps_pkg::CMD_BEGIN);
    it.total_length  = 17'(len);
    it.info_answered = 1'b1;
    it.info_status   = PEER_VALID;
    it.info_size     = 32'(len);
    it.info_crc      = it.total_crc;
    if (!peer_has) begin
      case ($urandom_range(0, 4))
        0: it.info_answered = 1'b0;
        1: it.info_status   = PEER_VALID ^ 8'($urandom_range(1, 255));
        2: it.info_size     = it.info_size ^ (32'h1 << $urandom_range(0, 31));
        3: it.info_crc      = it.info_crc ^ $urandom_range(1, 32'hFFFF_FFFF);
        default: it = any_fields(cps_pkg::CMD_BEGIN);
      endcase
      it.total_length = 17'(len);
    end
    return it;
  endfunction

  function automatic upload_item_t reply_item(logic [2:0] cmd, bit good);
    upload_item_t it;
    it = any_fields(cmd);
    if (good) begin
      it.completion_code = 8'h00;
      it.reply_short     = 1'b0;
    end else if (cmd == cps_pkg::CMD_START_REPLY && $urandom_range(0, 1) == 1) begin
      it.reply_short = 1'b1;
    end else begin
      it.completion_code = 8'($urandom_range(1, 255));
    end
    return it;
  endfunction

  function automatic upload_item_t noise_item();
    upload_item_t it;
    it = any_fields(3'($urandom_range(0, 7)));
    if (it.command == cps_pkg::CMD_BEGIN) begin
      it.total_length = $urandom_range(0, 1) ?
                        17'($urandom_range(0, 40)) :
                        17'($urandom_range(cps_pkg::MaxPayload + 1, 17'h1FFFF));
    end
    return it;
  endfunction

  task automatic send_item(upload_item_t it);
    int gap;
    gap = draw_gap(in_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    drv      <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic run_upload(int len, bit peer_has);
    send_item(begin_item(len, peer_has));
    while (sb.phase != cps_pkg::PH_IDLE) begin
      if ($urandom_range(0, 99) < 4) begin
        send_item(noise_item());
      end else begin
        case (sb.phase)
          cps_pkg::PH_WAIT_START:
            send_item(reply_item(cps_pkg::CMD_START_REPLY, $urandom_range(0, 19) != 0));
          cps_pkg::PH_DATA:
            send_item(any_fields(cps_pkg::CMD_DATA));
          cps_pkg::PH_WAIT_CHUNK:
            send_item(reply_item(cps_pkg::CMD_CHUNK_REPLY, $urandom_range(0, 39) != 0));
          default:
            send_item(reply_item(cps_pkg::CMD_END_REPLY, $urandom_range(0, 9) != 0));
        endcase
      end
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3 * sb.eff_chunk());
    if (r < 90) return $urandom_range(1, 100);
    return $urandom_range(100, 300);
  endfunction

  initial begin
    upload_result_t got;
    int gap;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = draw_gap(out_calm);
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
      got.action = action;
      got.length = length_out;
      got.crc    = crc_out;
      got.rid    = resource_id_out;
      got.offset = offset_out;
      got.last   = last;
      sb.check_result(got);
    end
  end

  initial begin
    upload_item_t it;
    logic [7:0] type_set[6];
    logic [7:0] size_set[6];
    logic [7:0] csize;
    int w;

    sb         = new();
    items_sent = 0;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = cps_pkg::CFG_PAYLOAD_TYPE;
    cfg_data   = 8'h00;
    in_valid   = 1'b0;
    drv        = '0;
    type_set   = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'h81};
    size_set   = '{8'd1, 8'd48, 8'hC0, 8'd63, 8'd7, 8'd0};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset configuration
    it = '0;
    it.command = cps_pkg::CMD_DATA;
    send_item(it);
    send_item(any_fields(CMD_SPARE_HI));
    send_item(any_fields(CMD_SPARE_LO));
    send_item(begin_item(0, 1'b1));
    it = '1;
    it.command = cps_pkg::CMD_BEGIN;
    send_item(it);
    send_item(begin_item(cps_pkg::MaxPayload, 1'b1));
    it = begin_item(cps_pkg::MaxPayload, 1'b1);
    it.info_status = 8'h02;
    send_item(it);
    it = reply_item(cps_pkg::CMD_START_REPLY, 1'b1);
    it.reply_short = 1'b1;
    send_item(it);
    it = begin_item(3, 1'b1);
    it.info_size = 32'd4;
    send_item(it);
    it = reply_item(cps_pkg::CMD_START_REPLY, 1'b1);
    it.completion_code = 8'hFF;
    send_item(it);

    it = begin_item(2, 1'b0);
    it.total_crc = '0;
    send_item(it);
    it = reply_item(cps_pkg::CMD_START_REPLY, 1'b1);
    it.reply_resource_id = 32'hFFFF_FFFF;
    send_item(it);
    it = any_fields(cps_pkg::CMD_DATA);
    it.data_value = 8'hFF;
    send_item(it);
    it.data_value = 8'h00;
    send_item(it);
    send_item(reply_item(cps_pkg::CMD_CHUNK_REPLY, 1'b1));
    send_item(reply_item(cps_pkg::CMD_END_REPLY, 1'b1));

    send_item(begin_item(1, 1'b0));
    it = reply_item(cps_pkg::CMD_START_REPLY, 1'b1);
    it.reply_resource_id = '0;
    send_item(it);
    send_item(any_fields(cps_pkg::CMD_DATA));
    it = reply_item(cps_pkg::CMD_CHUNK_REPLY, 1'b1);
    it.completion_code = 8'h01;
    send_item(it);

    send_item(begin_item(1, 1'b0));
    send_item(reply_item(cps_pkg::CMD_START_REPLY, 1'b1));
    send_item(any_fields(cps_pkg::CMD_DATA));
    send_item(reply_item(cps_pkg::CMD_CHUNK_REPLY, 1'b1));
    it = reply_item(cps_pkg::CMD_END_REPLY, 1'b1);
    it.completion_code = 8'h80;
    send_item(it);

    // begin while a transfer is open
    send_item(begin_item(5, 1'b0));
    send_item(reply_item(cps_pkg::CMD_START_REPLY, 1'b1));
    send_item(begin_item(1, 1'b1));

    // random uploads under several register settings
    for (int s = 0; s < 6; s++) begin
      wait_idle();
      csize = (s == 5) ? 8'($urandom_range(0, 255)) : size_set[s];
      write_reg(cps_pkg::CFG_PAYLOAD_TYPE, type_set[s]);
      write_reg(cps_pkg::CFG_CHUNK_SIZE, csize);
      while (items_sent < 25 + (s + 1) * 180) begin
        run_upload(pick_length(), $urandom_range(0, 9) == 0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    for (w = 0; w < 20000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
